// File: sv/capm_pkg.sv
// Package for the cascaded attitude PID mixer: types, limits and helpers.
// Used by capm_axis_lane, capm_mixer and cascaded_attitude_pid_mixer; no dependencies.
package capm_pkg;
   localparam int MOTOR_BITS_DEF     = 10;
   localparam int GAIN_FRAC_BITS_DEF = 12;
   localparam int GAINS_W            = 48;
   localparam int CSR_IDX_W          = 3;
   localparam int AXES               = 3;
   localparam logic signed [15:0] ANGLE_I_LIM = 16'sd4800;
   localparam logic signed [15:0] RATE_I_LIM  = 16'sd16000;
   localparam logic signed [17:0] RATE_SEP    = 18'sd2400;
   localparam int IDLE_THROTTLE      = 110;
   localparam int MOTOR_MIN_RESET    = 100;
   localparam int MOTOR_MAX_RESET    = 200;
   localparam logic [GAINS_W-1:0] PITCH_RATE_GAINS_RESET = 48'd82;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PITCH_ANGLE = 3'd0, CSR_ROLL_ANGLE = 3'd1, CSR_YAW_ANGLE = 3'd2,
      CSR_PITCH_RATE  = 3'd3, CSR_ROLL_RATE  = 3'd4, CSR_YAW_RATE  = 3'd5,
      CSR_MOTOR_MIN   = 3'd6, CSR_MOTOR_MAX  = 3'd7
   } csr_idx_type;

   // Per-tick lane command from the top level.
   typedef struct packed {
      logic start;
      logic active;
   } lane_ctl_type;

   function automatic logic signed [15:0] clamp16(input logic signed [17:0] v,
                                                  input logic signed [15:0] lim);
      logic signed [17:0] l;
      l = 18'(lim);
      if (v > l) return lim;
      if (v < -l) return -lim;
      return v[15:0];
   endfunction
endpackage

// File: sv/capm_axis_lane.sv
// One axis of the cascaded controller: outer angle PID then inner rate PID,
// on one shared 16x18 multiplier over six products. Uses capm_pkg.
module capm_axis_lane import capm_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctl_type              ctl,
   input  logic [GAINS_W-1:0]        angle_gains,
   input  logic [GAINS_W-1:0]        rate_gains,
   input  logic signed [15:0]        target,
   input  logic signed [15:0]        angle,
   input  logic signed [15:0]        rate,
   output logic signed [15:0]        core,
   output logic                      done
);
   localparam int ACC_W = 40;
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_OUTER = 5'b00010, S_OSAT = 5'b00100,
      S_INNER = 5'b01000, S_ISAT = 5'b10000
   } st_type;

   st_type              st_ff, st_in;
   logic [1:0]          k_ff, k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [15:0]  ai_ff, ai_in, pa_ff, pa_in, ri_ff, ri_in, pr_ff, pr_in;
   logic signed [15:0]  sp_ff, sp_in, core_ff, core_in;
   logic signed [17:0]  e_ff, e_in, r_ff, r_in;
   logic                usei_ff, usei_in, done_ff, done_in;
   logic [GAINS_W-1:0]  g;
   logic signed [15:0]  gk;
   logic signed [17:0]  opnd;
   logic signed [33:0]  prod;
   logic signed [ACC_W-1:0] q;
   logic signed [17:0]  e_now, asum;

   assign g = (st_ff == S_OUTER) ? angle_gains : rate_gains;
   always_comb begin
      case (k_ff)
         2'd0:    gk = g[15:0];
         2'd1:    gk = g[31:16];
         default: gk = g[47:32];
      endcase
   end
   always_comb begin
      if (st_ff == S_OUTER) begin
         case (k_ff)
            2'd0:    opnd = e_ff;
            2'd1:    opnd = 18'(ai_ff);
            default: opnd = 18'(angle) - 18'(pa_ff);
         endcase
      end else begin
         case (k_ff)
            2'd0:    opnd = r_ff;
            2'd1:    opnd = usei_ff ? 18'(ri_ff) : 18'sd0;
            default: opnd = 18'(rate) - 18'(pr_ff);
         endcase
      end
   end
   assign prod  = gk * opnd;
   assign q     = acc_ff >>> GAIN_FRAC_BITS;
   assign e_now = 18'(target) - 18'(angle);
   assign asum  = 18'(ai_ff) + e_now;

   always_comb begin
      st_in = st_ff; k_in = k_ff; acc_in = acc_ff; ai_in = ai_ff; pa_in = pa_ff;
      ri_in = ri_ff; pr_in = pr_ff; sp_in = sp_ff; core_in = core_ff;
      e_in = e_ff; r_in = r_ff; usei_in = usei_ff; done_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (ctl.start) begin
               e_in   = e_now;
               ai_in  = clamp16(asum, ANGLE_I_LIM);
               acc_in = '0;
               k_in   = 2'd0;
               st_in  = S_OUTER;
            end
         end
         S_OUTER, S_INNER: begin
            acc_in = acc_ff + ACC_W'(prod);
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               k_in  = 2'd0;
               st_in = (st_ff == S_OUTER) ? S_OSAT : S_ISAT;
            end
         end
         S_OSAT: begin
            if (q > ACC_W'(32767)) sp_in = 16'sh7fff;
            else if (q < -ACC_W'(32768)) sp_in = 16'sh8000;
            else sp_in = q[15:0];
            pa_in   = angle;
            r_in    = 18'(sp_in) - 18'(rate);
            usei_in = (r_in < RATE_SEP) && (r_in > -RATE_SEP);
            if (usei_in) ri_in = clamp16(18'(ri_ff) + r_in, RATE_I_LIM);
            acc_in  = '0;
            st_in   = S_INNER;
         end
         S_ISAT: begin
            if (q > ACC_W'(32767)) core_in = 16'sh7fff;
            else if (q < -ACC_W'(32768)) core_in = 16'sh8000;
            else core_in = q[15:0];
            pr_in = rate;
            if (!ctl.active) begin
               ai_in = '0; ri_in = '0; core_in = '0;
            end
            done_in = 1'b1;
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; k_ff <= '0; done_ff <= 1'b0;
         ai_ff <= '0; pa_ff <= '0; ri_ff <= '0; pr_ff <= '0;
      end else begin
         st_ff <= st_in; k_ff <= k_in; done_ff <= done_in;
         ai_ff <= ai_in; pa_ff <= pa_in; ri_ff <= ri_in; pr_ff <= pr_in;
      end
      acc_ff <= acc_in; sp_ff <= sp_in; core_ff <= core_in;
      e_ff <= e_in; r_ff <= r_in; usei_ff <= usei_in;
   end
   assign core = core_ff;
   assign done = done_ff;
endmodule

// File: sv/capm_mixer.sv
// Quad-X mixer: merges the three lane outputs with throttle and clamps.
// Uses capm_pkg.
module capm_mixer import capm_pkg::*; #(
   parameter int MOTOR_BITS = MOTOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  armed,
   input  logic [MOTOR_BITS-1:0] throttle,
   input  logic [MOTOR_BITS-1:0] motor_min,
   input  logic [MOTOR_BITS-1:0] motor_max,
   input  logic signed [15:0]    pitch,
   input  logic signed [15:0]    roll,
   input  logic signed [15:0]    yaw,
   output logic [4*MOTOR_BITS-1:0] motors
);
   localparam int SW = MOTOR_BITS + 20;
   logic signed [SW-1:0] t, p, r, y, mx, mn;
   logic signed [SW-1:0] m [4];
   logic [4*MOTOR_BITS-1:0] mot_ff, mot_in;

   assign t  = SW'($signed({1'b0, throttle}));
   assign p  = SW'(pitch);
   assign r  = SW'(roll);
   assign y  = SW'(yaw);
   assign mx = SW'($signed({1'b0, motor_max}));
   assign mn = SW'($signed({1'b0, motor_min}));
   assign m[0] = t - r + p + y;
   assign m[1] = t + r + p - y;
   assign m[2] = t + r - p + y;
   assign m[3] = t - r - p - y;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (!armed) mot_in[i*MOTOR_BITS +: MOTOR_BITS] = motor_min;
         else if (m[i] >= mx) mot_in[i*MOTOR_BITS +: MOTOR_BITS] = motor_max;
         else if (m[i] <= mn) mot_in[i*MOTOR_BITS +: MOTOR_BITS] = motor_min;
         else mot_in[i*MOTOR_BITS +: MOTOR_BITS] = m[i][MOTOR_BITS-1:0];
      end
   end
   always_ff @(posedge clock) begin
      mot_ff <= mot_in;
   end
   assign motors = mot_ff;
endmodule

// File: sv/cascaded_attitude_pid_mixer.sv
// Top level of the cascaded attitude PID controller and quad-X mixer.
// Depends on capm_pkg, capm_axis_lane and capm_mixer.
//
// Channel | Direction | Contents
// req_    | in        | tdata: angles, rates, targets, throttle, armed
// rsp_    | out       | tdata: four motor drive values
// csr_    | in        | write enable, register index, 48-bit data
//
// The accepted transaction is registered and the lanes start in the cycle
// after acceptance. The three lanes run in parallel: a start step, three
// products on each lane's single multiplier for the outer loop, a
// saturation step, three products for the inner loop and a second
// saturation step. The done pulse, mix_ff and the output valid register
// follow in that order. Reset is synchronous and returns all integrals,
// history, yaw hold and gains to their reset values. One transaction is
// in flight at a time; a held result stalls new requests.
module cascaded_attitude_pid_mixer import capm_pkg::*; #(
   parameter int MOTOR_BITS     = MOTOR_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // From bit 0: pitch_angle 13, roll_angle 13, yaw_angle 13, rate_x 16,
   // rate_y 16, rate_z 16, pitch_target 10, roll_target 10, throttle, armed,
   // then zero fill to whole bytes.
   input  logic [((108+MOTOR_BITS+7)/8)*8-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // From bit 0: motor_front_a, motor_front_b, motor_rear_a, motor_rear_b.
   output logic [((4*MOTOR_BITS+7)/8)*8-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [GAINS_W-1:0]      csr_wdata
);
   localparam int TW = 108 + MOTOR_BITS;
   localparam int RW = ((4*MOTOR_BITS+7)/8)*8;

   logic [GAINS_W-1:0]    ag_ff [AXES];
   logic [GAINS_W-1:0]    rg_ff [AXES];
   logic [MOTOR_BITS-1:0] mmin_ff, mmax_ff;
   logic signed [15:0]    yaw_hold_ff;
   logic [TW-1:0]         item_ff;
   logic                  busy_ff, mix_ff, out_v_ff, start_ff;
   logic signed [15:0]    ang [AXES], rt [AXES], tg [AXES], core [AXES];
   logic [AXES-1:0]       done;
   logic [MOTOR_BITS-1:0] thr;
   logic                  armed, active, accept;
   lane_ctl_type          ctl;
   logic [4*MOTOR_BITS-1:0] motors;

   // Configuration writes; all eight indexes name a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            ag_ff[i] <= '0;
            rg_ff[i] <= '0;
         end
         rg_ff[0] <= PITCH_RATE_GAINS_RESET;
         mmin_ff  <= MOTOR_BITS'(MOTOR_MIN_RESET);
         mmax_ff  <= MOTOR_BITS'(MOTOR_MAX_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PITCH_ANGLE: ag_ff[0] <= csr_wdata;
            CSR_ROLL_ANGLE:  ag_ff[1] <= csr_wdata;
            CSR_YAW_ANGLE:   ag_ff[2] <= csr_wdata;
            CSR_PITCH_RATE:  rg_ff[0] <= csr_wdata;
            CSR_ROLL_RATE:   rg_ff[1] <= csr_wdata;
            CSR_YAW_RATE:    rg_ff[2] <= csr_wdata;
            CSR_MOTOR_MIN:   mmin_ff  <= csr_wdata[MOTOR_BITS-1:0];
            CSR_MOTOR_MAX:   mmax_ff  <= csr_wdata[MOTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Unpack the held transaction; axis order is pitch, roll, yaw.
   assign ang[0] = 16'($signed(item_ff[12:0]));
   assign ang[1] = 16'($signed(item_ff[25:13]));
   assign ang[2] = 16'($signed(item_ff[38:26]));
   assign rt[1]  = item_ff[54:39];
   assign rt[0]  = item_ff[70:55];
   assign rt[2]  = item_ff[86:71];
   assign tg[0]  = 16'($signed(item_ff[96:87]));
   assign tg[1]  = 16'($signed(item_ff[106:97]));
   assign tg[2]  = yaw_hold_ff;
   assign thr    = item_ff[107 +: MOTOR_BITS];
   assign armed  = item_ff[TW-1];
   assign active = armed && (32'(thr) > IDLE_THROTTLE);

   assign req_tready = !busy_ff && !out_v_ff;
   assign accept     = req_tvalid && req_tready;
   // The lanes start once the transaction sits in item_ff.
   assign ctl.start  = start_ff;
   assign ctl.active = active;

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_tdata[TW-1:0];
   end

   // Lanes are started together and finish together.
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      capm_axis_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane (
         .clock(clock), .reset(reset), .ctl(ctl),
         .angle_gains(ag_ff[a]), .rate_gains(rg_ff[a]),
         .target(tg[a]), .angle(ang[a]), .rate(rt[a]),
         .core(core[a]), .done(done[a])
      );
   end

   capm_mixer #(.MOTOR_BITS(MOTOR_BITS)) u_mix (
      .clock(clock), .armed(armed), .throttle(thr),
      .motor_min(mmin_ff), .motor_max(mmax_ff),
      .pitch(core[0]), .roll(core[1]), .yaw(core[2]), .motors(motors)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         mix_ff      <= 1'b0;
         out_v_ff    <= 1'b0;
         start_ff    <= 1'b0;
         yaw_hold_ff <= '0;
      end else begin
         mix_ff   <= &done;
         start_ff <= accept;
         if (accept) busy_ff <= 1'b1;
         if (&done && !active) yaw_hold_ff <= ang[2];
         if (mix_ff) begin
            busy_ff  <= 1'b0;
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RW'(motors);
endmodule
